@@ rtl/lvr_pkg.sv @@
// Shared widths, codes and defaults for the low-variance resampler.
package lvr_pkg;

    // Field widths of the transaction and register interface.
    localparam int WEIGHT_W     = 32;
    localparam int INDEX_W      = 10;
    localparam int STATUS_W     = 2;
    localparam int OUT_COUNT_W  = 11;
    localparam int OFFSET_W     = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    // Target numerator is {draw number, offset fraction}.
    localparam int NUM_W        = OUT_COUNT_W + OFFSET_W;

    // The shared multiplier consumes one 16-bit slice of its wide operand per cycle.
    localparam int CHUNK_W      = 16;

    // Default sizing.
    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int WEIGHT_BITS_DEF   = 32;

    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_RESET   = 11'd1000;
    localparam logic [OFFSET_W-1:0]    OFFSET_FRAC_RESET = 16'd0;

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSET = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_FRAC = 1'd1;

endpackage

@@ rtl/lvr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/low_variance_resampler_core.sv @@
// Top level of the systematic low-variance particle resampler.
//
// Load transactions (req_type 0) store one weight each while there is room; set_end closes
// the set. Each draw transaction (req_type 1) returns one particle index, found by walking
// a pointer over the cumulative weights while the exact target product is strictly larger.
// All products run through one shared 27x16 multiplier that handles one 16-bit slice of its
// wide operand per cycle, with NCH = ceil((min(WEIGHT_BITS, 32) + log2(MAX_PARTICLES))
// / 16) slices (3 at the defaults). A draw forms the target product, then the product of
// count and cumulative weight, then compares them; each pointer step adds the next weight
// and forms the cumulative product again. A draw with an error status goes straight to
// its result. A finished result also waits while the previous one is still held by the
// consumer. The input is not ready while a draw is being worked on. Configuration is taken
// at any cycle; a draw in progress can see it too. No clearing pass is needed after reset.
module low_variance_resampler_core #(
    parameter int MAX_PARTICLES = lvr_pkg::MAX_PARTICLES_DEF,
    parameter int WEIGHT_BITS   = lvr_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input transaction channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [lvr_pkg::WEIGHT_W-1:0]      s_weight,
    input  logic                              s_set_end,
    // Result transaction channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lvr_pkg::INDEX_W-1:0]       m_chosen_index,
    output logic                              m_final_draw,
    output logic [lvr_pkg::STATUS_W-1:0]      m_status,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [lvr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lvr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import lvr_pkg::*;

    // Derived sizes.
    localparam int SW    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int PTRW  = $clog2(MAX_PARTICLES);
    localparam int NW    = $clog2(MAX_PARTICLES + 1);
    localparam int TW    = SW + PTRW;
    localparam int NCH   = (TW + CHUNK_W - 1) / CHUNK_W;
    localparam int BPW   = NCH * CHUNK_W;
    localparam int MA    = (NUM_W > NW) ? NUM_W : NW;
    localparam int PRODW = MA + CHUNK_W;
    localparam int ACCW  = MA + BPW;
    localparam int CNTW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [CNTW-1:0] CHUNK_TOP = CNTW'(NCH - 1);
    localparam logic [NW-1:0]   MAX_N     = NW'(MAX_PARTICLES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL_L  = 6'b000010,
        S_MUL_R  = 6'b000100,
        S_CMP    = 6'b001000,
        S_ADD    = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          cum_reg, cum_next;
    logic [PTRW-1:0]        ptr_reg, ptr_next;
    logic [OUT_COUNT_W-1:0] draws_reg, draws_next;
    logic                   set_ready_reg, set_ready_next;
    logic [OUT_COUNT_W-1:0] out_count_reg, out_count_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [CNTW-1:0]        chunk_reg, chunk_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload state.
    logic [SW-1:0]          first_reg, first_next;
    logic [ACCW-1:0]        acc_reg, acc_next;
    logic [ACCW-1:0]        lhs_reg, lhs_next;
    logic [INDEX_W-1:0]     res_index_reg, res_index_next;
    logic                   res_final_reg, res_final_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [INDEX_W-1:0]     m_index_reg, m_index_next;
    logic                   m_final_reg, m_final_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    // Datapath signals.
    logic                   in_accept;
    logic                   out_free;
    logic [SW-1:0]          w_in;
    logic [NW-1:0]          base_n;
    logic [TW-1:0]          base_total;
    logic                   room;
    logic [NW-1:0]          load_n;
    logic [SW-1:0]          load_first;
    logic [STATUS_W-1:0]    draw_status;
    logic [MA-1:0]          mul_a;
    logic [BPW-1:0]         mul_b;
    logic [CHUNK_W-1:0]     mul_chunk;
    logic [PRODW-1:0]       mul_prod;
    logic [ACCW-1:0]        acc_sum;
    logic [NW:0]            ptr_inc;
    logic                   can_step;
    logic                   beyond;
    logic [OUT_COUNT_W-1:0] draws_inc;
    logic                   ram_we;
    logic                   ram_re;
    logic [SW-1:0]          ram_rdata;

    // Weight store.
    lvr_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_PARTICLES)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (base_n[PTRW-1:0]),
        .wdata (w_in),
        .re    (ram_re),
        .raddr (ptr_inc[PTRW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Load path: a closed set is restarted by the first new load.
    assign w_in       = SW'(s_weight);
    assign base_n     = set_ready_reg ? '0 : n_reg;
    assign base_total = set_ready_reg ? '0 : total_reg;
    assign room       = (base_n < MAX_N);
    assign load_n     = room ? (base_n + NW'(1)) : base_n;
    assign load_first = (room && (base_n == '0)) ? w_in : first_reg;
    assign ram_we     = in_accept && (s_req_type == REQ_LOAD) && room;

    // Draw error checks, in priority order.
    always_comb begin
        if (!set_ready_reg || (n_reg == '0)) begin
            draw_status = ST_NOSET;
        end else if (total_reg == '0) begin
            draw_status = ST_ZERO;
        end else if (draws_reg >= out_count_reg) begin
            draw_status = ST_DONE;
        end else begin
            draw_status = ST_OK;
        end
    end

    // Shared multiplier: most significant slice first, accumulate with a 16-bit shift.
    assign mul_a     = (state_reg == S_MUL_L) ? MA'({draws_reg, offset_reg}) : MA'(n_reg);
    assign mul_b     = (state_reg == S_MUL_L) ? BPW'(total_reg) : BPW'(cum_reg);
    assign mul_chunk = mul_b[chunk_reg*CHUNK_W +: CHUNK_W];
    assign mul_prod  = PRODW'(mul_a) * PRODW'(mul_chunk);
    assign acc_sum   = ((chunk_reg == CHUNK_TOP) ? '0 : (acc_reg << CHUNK_W)) + ACCW'(mul_prod);

    // Walk decision: target strictly beyond cumulative weight times count times 65536.
    assign ptr_inc   = {{(NW + 1 - PTRW){1'b0}}, ptr_reg} + (NW + 1)'(1);
    assign can_step  = (ptr_inc < {1'b0, n_reg});
    assign beyond    = ({{CHUNK_W{1'b0}}, lhs_reg} > {acc_reg, {CHUNK_W{1'b0}}});
    assign draws_inc = draws_reg + OUT_COUNT_W'(1);
    assign ram_re    = (state_reg == S_CMP);

    // Sequencer and next-state logic.
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        total_next      = total_reg;
        cum_next        = cum_reg;
        ptr_next        = ptr_reg;
        draws_next      = draws_reg;
        set_ready_next  = set_ready_reg;
        out_count_next  = out_count_reg;
        offset_next     = offset_reg;
        chunk_next      = chunk_reg;
        m_valid_next    = m_valid_reg;
        first_next      = first_reg;
        acc_next        = acc_reg;
        lhs_next        = lhs_reg;
        res_index_next  = res_index_reg;
        res_final_next  = res_final_reg;
        res_status_next = res_status_reg;
        m_index_next    = m_index_reg;
        m_final_next    = m_final_reg;
        m_status_next   = m_status_reg;

        // Result register drains when the consumer takes the transaction.
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_we) begin
            case (cfg_index)
                CFG_OUT_COUNT:   out_count_next = cfg_wdata[OUT_COUNT_W-1:0];
                CFG_OFFSET_FRAC: offset_next    = cfg_wdata[OFFSET_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (s_req_type == REQ_LOAD) begin
                        n_next         = load_n;
                        total_next     = room ? (base_total + TW'(w_in)) : base_total;
                        first_next     = load_first;
                        set_ready_next = 1'b0;
                        if (s_set_end) begin
                            set_ready_next = 1'b1;
                            draws_next     = '0;
                            ptr_next       = '0;
                            cum_next       = (load_n != '0) ? TW'(load_first) : '0;
                        end
                    end else if (draw_status != ST_OK) begin
                        res_index_next  = '0;
                        res_final_next  = 1'b0;
                        res_status_next = draw_status;
                        state_next      = S_RESULT;
                    end else begin
                        chunk_next = CHUNK_TOP;
                        state_next = S_MUL_L;
                    end
                end
            end
            S_MUL_L: begin
                acc_next = acc_sum;
                if (chunk_reg == '0) begin
                    lhs_next   = acc_sum;
                    chunk_next = CHUNK_TOP;
                    state_next = S_MUL_R;
                end else begin
                    chunk_next = chunk_reg - CNTW'(1);
                end
            end
            S_MUL_R: begin
                acc_next = acc_sum;
                if (chunk_reg == '0) begin
                    state_next = S_CMP;
                end else begin
                    chunk_next = chunk_reg - CNTW'(1);
                end
            end
            S_CMP: begin
                if (can_step && beyond) begin
                    state_next = S_ADD;
                end else begin
                    draws_next      = draws_inc;
                    res_index_next  = INDEX_W'(ptr_reg);
                    res_final_next  = (draws_inc == out_count_reg);
                    res_status_next = ST_OK;
                    state_next      = S_RESULT;
                end
            end
            S_ADD: begin
                cum_next   = cum_reg + TW'(ram_rdata);
                ptr_next   = ptr_inc[PTRW-1:0];
                chunk_next = CHUNK_TOP;
                state_next = S_MUL_R;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_index_next  = res_index_reg;
                    m_final_next  = res_final_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            total_reg     <= '0;
            cum_reg       <= '0;
            ptr_reg       <= '0;
            draws_reg     <= '0;
            set_ready_reg <= 1'b0;
            out_count_reg <= OUT_COUNT_RESET;
            offset_reg    <= OFFSET_FRAC_RESET;
            chunk_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            total_reg     <= total_next;
            cum_reg       <= cum_next;
            ptr_reg       <= ptr_next;
            draws_reg     <= draws_next;
            set_ready_reg <= set_ready_next;
            out_count_reg <= out_count_next;
            offset_reg    <= offset_next;
            chunk_reg     <= chunk_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        first_reg      <= first_next;
        acc_reg        <= acc_next;
        lhs_reg        <= lhs_next;
        res_index_reg  <= res_index_next;
        res_final_reg  <= res_final_next;
        res_status_reg <= res_status_next;
        m_index_reg    <= m_index_next;
        m_final_reg    <= m_final_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_chosen_index = m_index_reg;
    assign m_final_draw   = m_final_reg;
    assign m_status       = m_status_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the low-variance resampler core with a draw-result scoreboard.
module testbench;
    import lvr_pkg::*;

    localparam int MAX_SLOTS     = 1024;
    localparam int ITEM_TARGET   = 2000;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;

    // One expected or observed draw result.
    typedef struct packed {
        logic [INDEX_W-1:0]  chosen_index;
        logic                final_draw;
        logic [STATUS_W-1:0] status;
    } draw_result_t;

    // Predicts the outcome of each accepted transaction and checks the results in order.
    class resampler_scoreboard;
        logic [OUT_COUNT_W-1:0] round_length;
        logic [OFFSET_W-1:0]    start_offset;
        logic [WEIGHT_W-1:0]    weights [MAX_SLOTS];
        logic [10:0]            particle_count;
        logic [41:0]            sum_of_weights;
        logic [41:0]            running_sum;
        logic [INDEX_W-1:0]     walk_index;
        logic [10:0]            draw_count;
        logic                   set_closed;
        draw_result_t           pending_draws [$];
        int                     error_count;

        function new();
            round_length   = OUT_COUNT_RESET;
            start_offset   = OFFSET_FRAC_RESET;
            particle_count = '0;
            sum_of_weights = '0;
            running_sum    = '0;
            walk_index     = '0;
            draw_count     = '0;
            set_closed     = 1'b0;
            error_count    = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_OUT_COUNT) begin
                round_length = data[OUT_COUNT_W-1:0];
            end else begin
                start_offset = data[OFFSET_W-1:0];
            end
        endfunction

        // Exact test of (offset + k*65536) * sum > running * count * 65536.
        function bit target_past_walk();
            logic [127:0] numerator;
            logic [127:0] total;
            logic [127:0] running;
            logic [127:0] scaled_count;
            numerator    = {draw_count, start_offset};
            total        = sum_of_weights;
            running      = running_sum;
            scaled_count = {particle_count, 16'h0000};
            return (numerator * total) > (running * scaled_count);
        endfunction

        function void note_input(logic req, logic [WEIGHT_W-1:0] weight, logic set_last);
            draw_result_t outcome;
            if (req == REQ_LOAD) begin
                // The first load after a closed set starts a new one.
                if (set_closed) begin
                    particle_count = '0;
                    sum_of_weights = '0;
                    set_closed     = 1'b0;
                end
                // A full store drops the weight but still honors the end flag.
                if (particle_count < MAX_SLOTS) begin
                    weights[particle_count] = weight;
                    particle_count          = particle_count + 11'd1;
                    sum_of_weights          = sum_of_weights + weight;
                end
                if (set_last) begin
                    set_closed  = 1'b1;
                    draw_count  = '0;
                    walk_index  = '0;
                    running_sum = (particle_count != 0) ? {10'b0, weights[0]} : '0;
                end
                return;
            end
            outcome = '0;
            if (!set_closed || particle_count == 0) begin
                outcome.status = ST_NOSET;
            end else if (sum_of_weights == 0) begin
                outcome.status = ST_ZERO;
            end else if (draw_count >= round_length) begin
                outcome.status = ST_DONE;
            end else begin
                // Advance while the target lies beyond the cumulative weight,
                // stopping at the last particle.
                while ((walk_index + 11'd1) < particle_count && target_past_walk()) begin
                    walk_index  = walk_index + 1'b1;
                    running_sum = running_sum + weights[walk_index];
                end
                draw_count            = draw_count + 11'd1;
                outcome.chosen_index  = walk_index;
                outcome.final_draw    = (draw_count == round_length);
                outcome.status        = ST_OK;
            end
            pending_draws = {pending_draws, outcome};
        endfunction

        function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(draw_result_t got);
            draw_result_t want;
            if (pending_draws.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction, expected none, %s %0d status %0d",
                         $time, "actual index", got.chosen_index, got.status);
                return;
            end
            want = pending_draws.pop_front();
            if (got.chosen_index !== want.chosen_index)
                report_mismatch("chosen_index", want.chosen_index, got.chosen_index);
            if (got.final_draw !== want.final_draw)
                report_mismatch("final_draw", want.final_draw, got.final_draw);
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
        endfunction

        function int pending();
            return pending_draws.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_req_type;
    logic [WEIGHT_W-1:0]    s_weight;
    logic                   s_set_end;
    logic                   m_valid;
    logic                   m_ready;
    logic [INDEX_W-1:0]     m_chosen_index;
    logic                   m_final_draw;
    logic [STATUS_W-1:0]    m_status;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    resampler_scoreboard sb;
    int items_sent;
    int burst_left;
    int cycle_count;
    int ready_run;
    int stall_run;
    bit big_set_done;

    low_variance_resampler_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_weight       (s_weight),
        .s_set_end      (s_set_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chosen_index (m_chosen_index),
        .m_final_draw   (m_final_draw),
        .m_status       (m_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Cycle counter that ends a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge aclk) begin : result_monitor
        draw_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.chosen_index = m_chosen_index;
            got.final_draw   = m_final_draw;
            got.status       = m_status;
            sb.check_result(got);
        end
        if (stall_run > 0) begin
            m_ready <= 1'b0;
            stall_run--;
        end else if (ready_run > 0) begin
            m_ready <= 1'b1;
            ready_run--;
        end else begin
            ready_run = $urandom_range(1, 20);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    end

    // Offers one transaction, possibly idling first when the current burst has run out.
    task automatic send_item(logic req, logic [WEIGHT_W-1:0] weight, logic set_last);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0) begin
                s_valid <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_weight   <= weight;
        s_set_end  <= set_last;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(req, weight, set_last);
        items_sent++;
    endtask

    task automatic send_draw();
        send_item(REQ_DRAW, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Drains all expected results and lets any trailing load transaction finish.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(logic [OUT_COUNT_W-1:0] count, logic [OFFSET_W-1:0] offset);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OUT_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(posedge aclk);
        sb.write_register(CFG_OUT_COUNT, CFG_DATA_W'(count));
        cfg_index <= CFG_OFFSET_FRAC;
        cfg_wdata <= offset;
        @(posedge aclk);
        sb.write_register(CFG_OFFSET_FRAC, offset);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return $urandom;
                    default: return 32'h1 << $urandom_range(0, 31);
                endcase
            end
            default: return '0;
        endcase
    endfunction

    // One resampling round: optionally a new set, then a run of draws.
    task automatic run_round(bit skip_load);
        int size;
        int mode;
        int draws;
        bit open_end;
        if (!skip_load) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: size = $urandom_range(1, 4);
                6, 7, 8:          size = $urandom_range(5, 16);
                default:          size = $urandom_range(17, 64);
            endcase
            mode     = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
            open_end = ($urandom_range(0, 11) == 0);
            for (int i = 0; i < size; i++) begin
                // Occasional draw while the set is still open.
                if ($urandom_range(0, 19) == 0)
                    send_draw();
                send_item(REQ_LOAD, pick_weight(mode), (i == size - 1) && !open_end);
            end
        end
        if (sb.round_length == 0)
            draws = 2;
        else if (sb.round_length <= 16)
            draws = sb.round_length + $urandom_range(0, 2);
        else
            draws = $urandom_range(1, 40);
        repeat (draws) send_draw();
    endtask

    // A fresh register setting followed by a few rounds.
    task automatic run_phase();
        logic [OUT_COUNT_W-1:0] count;
        logic [OFFSET_W-1:0]    offset;
        int                     rounds;
        case ($urandom_range(0, 9))
            0:       count = 11'd1;
            1:       count = 11'd0;
            2:       count = 11'd2047;
            3:       count = 11'($urandom_range(1, 1024));
            4:       count = 11'd1024;
            default: count = 11'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 3))
            0:       offset = 16'h0000;
            1:       offset = 16'hFFFF;
            default: offset = $urandom;
        endcase
        wait_quiet();
        write_regs(count, offset);
        rounds = $urandom_range(1, 4);
        for (int r = 0; r < rounds; r++)
            run_round(r == 0 && $urandom_range(0, 5) == 0);
    endtask

    // Overfills the weight store, then walks a long cumulative sum.
    task automatic run_full_store();
        wait_quiet();
        write_regs(11'd1024, $urandom);
        for (int i = 0; i < MAX_SLOTS + 3; i++)
            send_item(REQ_LOAD, pick_weight(0), i == MAX_SLOTS + 2);
        repeat (30) send_draw();
        wait_quiet();
        write_regs(11'd50, $urandom);
        for (int i = 0; i < MAX_SLOTS / 4; i++)
            send_item(REQ_LOAD, pick_weight(2), i == MAX_SLOTS / 4 - 1);
        repeat (51) send_draw();
    endtask

    // Reset, directed checks, random traffic, then drain and verdict.
    initial begin
        sb           = new();
        items_sent   = 0;
        burst_left   = 0;
        cycle_count  = 0;
        ready_run    = 0;
        stall_run    = 0;
        big_set_done = 1'b0;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= REQ_LOAD;
        s_weight   <= '0;
        s_set_end  <= 1'b0;
        m_ready    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_OUT_COUNT;
        cfg_wdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Draw before any set, a zero-sum set, and a draw into an open set.
        send_draw();
        send_item(REQ_LOAD, '0, 1'b1);
        send_draw();
        send_item(REQ_LOAD, 32'h1, 1'b0);
        send_draw();
        send_item(REQ_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_item(REQ_LOAD, '0, 1'b0);
        send_item(REQ_LOAD, 32'h8000_0000, 1'b1);
        repeat (3) send_draw();

        // Shorter round than already drawn, then a full round and one draw past its end.
        wait_quiet();
        write_regs(11'd2, 16'hFFFF);
        send_draw();
        send_item(REQ_LOAD, 32'd5, 1'b0);
        send_item(REQ_LOAD, '0, 1'b0);
        send_item(REQ_LOAD, 32'd7, 1'b1);
        repeat (3) send_draw();

        // A round length of zero completes every round at once.
        wait_quiet();
        write_regs(11'd0, 16'h0000);
        send_item(REQ_LOAD, 32'd9, 1'b1);
        send_draw();

        while (items_sent < ITEM_TARGET) begin
            if (!big_set_done && items_sent > 600) begin
                run_full_store();
                big_set_done = 1'b1;
            end else begin
                run_phase();
            end
        end

        wait_quiet();
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
